// ===== rtl/core/sos_pkg.sv =====
// ----------------------------------------------------------------------------
// sos_pkg
// Shared types and codes for the set-of-stacks block: command and status
// encodings and the fixed field widths of the item ports.
// ----------------------------------------------------------------------------
package sos_pkg;

  localparam int CMD_W   = 2;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 3;
  localparam int STAT_W  = 2;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam cmd_t CMD_PUSH   = 2'd0;
  localparam cmd_t CMD_POP    = 2'd1;
  localparam cmd_t CMD_POP_AT = 2'd2;

  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_OVERFLOW  = 2'd1;
  localparam status_t STAT_UNDERFLOW = 2'd2;

endpackage

// ===== rtl/core/set_of_stacks_with_pop_at.sv =====
// One item at a time: no new input beat is taken until its result is in the output register.
// Each item walks a fixed sequence: fill-count read, update of the count and
// element memories, a top fill-count read, then the element read.
// The output register frees the input side while a result waits.
// Reset clears the non-empty and full flags and the current sub-stack;
// memory contents stay undefined and are masked by those flags.
// ----------------------------------------------------------------------------
// set_of_stacks_with_pop_at
// Stack built from NUM_STACKS sub-stacks of SUB_DEPTH entries, with push,
// pop from the overall top and pop at a chosen sub-stack.
// ----------------------------------------------------------------------------
module set_of_stacks_with_pop_at #(
  parameter int NUM_STACKS = 8,
  parameter int SUB_DEPTH  = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sos_pkg::CMD_W-1:0]         command_i,
  input  logic signed [sos_pkg::DATA_W-1:0] value_i,
  input  logic [sos_pkg::INDEX_W-1:0]       stack_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sos_pkg::STAT_W-1:0]        status_o,
  output logic signed [sos_pkg::DATA_W-1:0] top_value_o,
  output logic                              top_valid_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);

  import sos_pkg::*;

  localparam int SW    = $clog2(NUM_STACKS);
  localparam int CW    = $clog2(SUB_DEPTH + 1);
  localparam int EDEPTH = NUM_STACKS * SUB_DEPTH;
  localparam int EW    = $clog2(EDEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_TOPC,
    ST_TOPE,
    ST_DONE
  } state_e;

  function automatic logic [SW:0] find_hi(logic [NUM_STACKS-1:0] flags,
                                          logic [SW-1:0] start);
    logic [SW:0] res;
    res = '0;
    for (int i = 0; i < NUM_STACKS; i++) begin
      if (flags[i] && (SW'(i) <= start)) begin
        res = {1'b1, SW'(i)};
      end
    end
    return res;
  endfunction

  function automatic logic [EW-1:0] elem_addr(logic [SW-1:0] idx, int slot);
    return EW'(int'(idx) * SUB_DEPTH + slot);
  endfunction

  state_e                  state_q, state_d;
  cmd_t                    op_q, op_d;
  logic                    ok_q, ok_d;
  logic [SW-1:0]           tgt_q, tgt_d;
  logic [DATA_W-1:0]       value_q, value_d;
  status_t                 stat_q, stat_d;
  logic                    cur_valid_q, cur_valid_d;
  logic [SW-1:0]           cur_q, cur_d;
  logic [NUM_STACKS-1:0]   nonempty_q, nonempty_d;
  logic [NUM_STACKS-1:0]   full_q, full_d;
  logic [SW-1:0]           top_idx_q, top_idx_d;
  logic                    top_valid_q, top_valid_d;
  logic                    res_empty_q, res_empty_d;
  logic                    res_full_q, res_full_d;
  logic                    out_valid_q, out_valid_d;
  status_t                 out_stat_q, out_stat_d;
  logic [DATA_W-1:0]       out_value_q, out_value_d;
  logic                    out_top_valid_q, out_top_valid_d;
  logic                    out_empty_q, out_empty_d;
  logic                    out_full_q, out_full_d;

  logic                    in_fire;
  logic [SW-1:0]           sat_idx;
  logic [SW:0]             hit_cur, hit_at;
  logic [SW-1:0]           dec_tgt;
  logic                    dec_ok;
  status_t                 dec_stat;
  logic [CW-1:0]           cnt;
  logic                    cur_valid_aft;
  logic [SW-1:0]           cur_aft;

  logic                    fill_we, fill_re;
  logic [SW-1:0]           fill_waddr, fill_raddr;
  logic [CW-1:0]           fill_wdata, fill_rdata;
  logic                    elem_we, elem_re;
  logic [EW-1:0]           elem_waddr, elem_raddr;
  logic [DATA_W-1:0]       elem_rdata;

  sos_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_STACKS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .re_i    (fill_re),
    .raddr_i (fill_raddr),
    .rdata_o (fill_rdata)
  );

  sos_ram #(
    .WIDTH (DATA_W),
    .DEPTH (EDEPTH)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (elem_waddr),
    .wdata_i (value_q),
    .re_i    (elem_re),
    .raddr_i (elem_raddr),
    .rdata_o (elem_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    if (int'(stack_index_i) >= NUM_STACKS) begin
      sat_idx = SW'(NUM_STACKS - 1);
    end else begin
      sat_idx = SW'(stack_index_i);
    end
  end

  assign hit_cur = find_hi(nonempty_q, cur_q);
  assign hit_at  = find_hi(nonempty_q, sat_idx);

  // decide target sub-stack for the incoming beat
  always_comb begin
    dec_tgt  = '0;
    dec_ok   = 1'b1;
    dec_stat = STAT_OK;
    unique case (command_i)
      CMD_PUSH: begin
        if (!cur_valid_q) begin
          dec_tgt = '0;
        end else if (full_q[cur_q]) begin
          dec_tgt = cur_q + 1'b1;
          dec_ok  = (cur_q != SW'(NUM_STACKS - 1));
        end else begin
          dec_tgt = cur_q;
        end
        if (dec_ok && full_q[dec_tgt]) begin
          dec_ok = 1'b0;
        end
        if (!dec_ok) begin
          dec_stat = STAT_OVERFLOW;
        end
      end
      CMD_POP: begin
        dec_ok  = cur_valid_q && hit_cur[SW];
        dec_tgt = hit_cur[SW-1:0];
        if (!dec_ok) begin
          dec_stat = STAT_UNDERFLOW;
        end
      end
      CMD_POP_AT: begin
        dec_ok  = hit_at[SW];
        dec_tgt = hit_at[SW-1:0];
        if (!dec_ok) begin
          dec_stat = STAT_UNDERFLOW;
        end
      end
      default: begin
        dec_ok = 1'b0;
      end
    endcase
  end

  assign cnt = nonempty_q[tgt_q] ? fill_rdata : '0;

  always_comb begin
    if (op_q == CMD_POP && ok_q) begin
      cur_valid_aft = hit_cur[SW];
      cur_aft       = hit_cur[SW] ? hit_cur[SW-1:0] : '0;
    end else begin
      cur_valid_aft = cur_valid_q;
      cur_aft       = cur_q;
    end
  end

  always_comb begin
    state_d         = state_q;
    op_d            = op_q;
    ok_d            = ok_q;
    tgt_d           = tgt_q;
    value_d         = value_q;
    stat_d          = stat_q;
    cur_valid_d     = cur_valid_q;
    cur_d           = cur_q;
    nonempty_d      = nonempty_q;
    full_d          = full_q;
    top_idx_d       = top_idx_q;
    top_valid_d     = top_valid_q;
    res_empty_d     = res_empty_q;
    res_full_d      = res_full_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    out_stat_d      = out_stat_q;
    out_value_d     = out_value_q;
    out_top_valid_d = out_top_valid_q;
    out_empty_d     = out_empty_q;
    out_full_d      = out_full_q;

    fill_we    = 1'b0;
    fill_waddr = tgt_q;
    fill_wdata = cnt;
    fill_re    = 1'b0;
    fill_raddr = dec_tgt;
    elem_we    = 1'b0;
    elem_waddr = elem_addr(tgt_q, int'(cnt));
    elem_re    = 1'b0;
    elem_raddr = elem_addr(top_idx_q, int'(fill_rdata) - 1);

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d    = command_i;
          ok_d    = dec_ok;
          tgt_d   = dec_tgt;
          value_d = value_i;
          stat_d  = dec_stat;
          fill_re = 1'b1;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (ok_q && op_q == CMD_PUSH) begin
          elem_we           = 1'b1;
          fill_we           = 1'b1;
          fill_wdata        = cnt + 1'b1;
          nonempty_d[tgt_q] = 1'b1;
          full_d[tgt_q]     = ((cnt + 1'b1) == CW'(SUB_DEPTH));
          cur_d             = tgt_q;
          cur_valid_d       = 1'b1;
        end else if (ok_q && (op_q == CMD_POP || op_q == CMD_POP_AT)) begin
          fill_we           = 1'b1;
          fill_wdata        = cnt - 1'b1;
          nonempty_d[tgt_q] = (cnt != CW'(1));
          full_d[tgt_q]     = 1'b0;
        end
        state_d = ST_TOPC;
      end
      ST_TOPC: begin
        // lower current after a pop, then find the top sub-stack
        cur_valid_d = cur_valid_aft;
        cur_d       = cur_aft;
        top_idx_d   = hit_cur[SW-1:0];
        top_valid_d = cur_valid_aft && hit_cur[SW];
        res_empty_d = !cur_valid_aft;
        res_full_d  = cur_valid_aft && (cur_aft == SW'(NUM_STACKS - 1)) && full_q[cur_aft];
        fill_re     = 1'b1;
        fill_raddr  = hit_cur[SW-1:0];
        state_d     = ST_TOPE;
      end
      ST_TOPE: begin
        elem_re = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d     = 1'b1;
          out_stat_d      = stat_q;
          out_value_d     = top_valid_q ? elem_rdata : '0;
          out_top_valid_d = top_valid_q;
          out_empty_d     = res_empty_q;
          out_full_d      = res_full_q;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_valid_q <= 1'b0;
      cur_q       <= '0;
      nonempty_q  <= '0;
      full_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q         <= state_d;
      op_q            <= op_d;
      ok_q            <= ok_d;
      tgt_q           <= tgt_d;
      value_q         <= value_d;
      stat_q          <= stat_d;
      cur_valid_q     <= cur_valid_d;
      cur_q           <= cur_d;
      nonempty_q      <= nonempty_d;
      full_q          <= full_d;
      top_idx_q       <= top_idx_d;
      top_valid_q     <= top_valid_d;
      res_empty_q     <= res_empty_d;
      res_full_q      <= res_full_d;
      out_valid_q     <= out_valid_d;
      out_stat_q      <= out_stat_d;
      out_value_q     <= out_value_d;
      out_top_valid_q <= out_top_valid_d;
      out_empty_q     <= out_empty_d;
      out_full_q      <= out_full_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_stat_q;
  assign top_value_o = out_value_q;
  assign top_valid_o = out_top_valid_q;
  assign is_empty_o  = out_empty_q;
  assign is_full_o   = out_full_q;

endmodule

// ===== rtl/core/sos_ram.sv =====
// ----------------------------------------------------------------------------
// sos_ram
// Generic single-port-write, single-port-read synchronous RAM. Read data is
// registered and holds while no read is issued.
// ----------------------------------------------------------------------------
module sos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for set_of_stacks_with_pop_at. A directed run fills the
// whole set, overflows it and punches holes with pop-at; random fill and
// drain phases follow. Each result beat is checked against an in-bench model
// of the sub-stacks, with random stalls on both handshakes.
// ----------------------------------------------------------------------------
module tb;
  import sos_pkg::*;

  localparam int NUM_STACKS = 8;
  localparam int SUB_DEPTH  = 2;
  localparam int RANDOM_OPS = 1500;
  localparam int QUIET_OPS  = 150;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam cmd_t CMD_NOP = 2'd3;

  typedef struct {
    cmd_t                      command;
    logic signed [DATA_W-1:0]  value;
    logic [INDEX_W-1:0]        stack_index;
  } stack_op_t;

  typedef struct {
    status_t                   status;
    logic signed [DATA_W-1:0]  top_value;
    logic                      top_valid;
    logic                      is_empty;
    logic                      is_full;
  } stack_view_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [CMD_W-1:0]          command_i = CMD_NOP;
  logic signed [DATA_W-1:0]  value_i = '0;
  logic [INDEX_W-1:0]        stack_index_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [STAT_W-1:0]         status_o;
  logic signed [DATA_W-1:0]  top_value_o;
  logic                      top_valid_o;
  logic                      is_empty_o;
  logic                      is_full_o;

  wire in_fire  = in_valid_i && in_ready_o;
  wire out_fire = out_valid_o && out_ready_i;

  stack_op_t   pending_ops[$];
  stack_view_t expected_views[$];
  stack_view_t want_view;

  int  total_ops;
  int  accepted_cnt = 0;
  int  fail_cnt = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  idle_pct = 25;
  bit  quiet_tail = 1'b0;
  int  stall_cycles = 0;

  // model state
  logic signed [DATA_W-1:0] elem_mem [NUM_STACKS][SUB_DEPTH];
  int  fill_cnt [NUM_STACKS];
  bit  cur_used = 1'b0;
  int  cur_stack = 0;

  logic [DATA_W-1:0] corner_vals [16] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE,
    32'h8000_0001, 32'h7FFF_FFFE, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
    32'h1234_5678, 32'hEDCB_A987, 32'h00FF_FF00, 32'hFF00_00FF
  };

  set_of_stacks_with_pop_at #(
    .NUM_STACKS (NUM_STACKS),
    .SUB_DEPTH  (SUB_DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .value_i       (value_i),
    .stack_index_i (stack_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .top_value_o   (top_value_o),
    .top_valid_o   (top_valid_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit find_filled(input int start, output int found);
    int i;
    i = (start >= NUM_STACKS) ? NUM_STACKS - 1 : start;
    found = 0;
    for (; i >= 0; i--) begin
      if (fill_cnt[i] != 0) begin
        found = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic stack_view_t apply_op(stack_op_t op);
    stack_view_t view;
    int idx;
    int tgt;
    bit ok;
    view.status    = STAT_OK;
    view.top_value = '0;
    view.top_valid = 1'b0;
    case (op.command)
      CMD_PUSH: begin
        ok = 1'b1;
        if (!cur_used) begin
          tgt = 0;
        end else if (fill_cnt[cur_stack] >= SUB_DEPTH) begin
          tgt = cur_stack + 1;
          if (tgt >= NUM_STACKS) ok = 1'b0;
        end else begin
          tgt = cur_stack;
        end
        if (ok && fill_cnt[tgt] >= SUB_DEPTH) ok = 1'b0;
        if (ok) begin
          elem_mem[tgt][fill_cnt[tgt]] = op.value;
          fill_cnt[tgt]++;
          cur_stack = tgt;
          cur_used = 1'b1;
        end else begin
          view.status = STAT_OVERFLOW;
        end
      end
      CMD_POP: begin
        if (cur_used && find_filled(cur_stack, idx)) begin
          fill_cnt[idx]--;
          if (find_filled(idx, idx)) begin
            cur_stack = idx;
          end else begin
            cur_used = 1'b0;
            cur_stack = 0;
          end
        end else begin
          view.status = STAT_UNDERFLOW;
        end
      end
      CMD_POP_AT: begin
        if (find_filled(op.stack_index, idx)) fill_cnt[idx]--;
        else view.status = STAT_UNDERFLOW;
      end
      default: ;
    endcase
    if (cur_used && find_filled(cur_stack, idx)) begin
      view.top_value = elem_mem[idx][fill_cnt[idx]-1];
      view.top_valid = 1'b1;
    end
    view.is_empty = !cur_used;
    view.is_full  = cur_used && cur_stack == NUM_STACKS - 1 &&
                    fill_cnt[cur_stack] >= SUB_DEPTH;
    return view;
  endfunction

  task automatic add_op(cmd_t cmd, logic [DATA_W-1:0] val, int index);
    stack_op_t op;
    op.command     = cmd;
    op.value       = val;
    op.stack_index = index[INDEX_W-1:0];
    pending_ops.push_back(op);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_fire) begin
        expected_views.push_back(apply_op(pending_ops.pop_front()));
        accepted_cnt++;
        if (accepted_cnt % 100 == 0) begin
          case ($urandom_range(0, 3))
            0: idle_pct <= 0;
            1: idle_pct <= 10;
            2: idle_pct <= 25;
            default: idle_pct <= 50;
          endcase
        end
        if (accepted_cnt + QUIET_OPS >= total_ops) quiet_tail <= 1'b1;
        if (!quiet_tail && $urandom_range(1, 100) <= idle_pct)
          send_gap = $urandom_range(1, 17);
      end
      if (!in_valid_i || in_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_valid_i    <= 1'b1;
          command_i     <= pending_ops[0].command;
          value_i       <= pending_ops[0].value;
          stack_index_i <= pending_ops[0].stack_index;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_fire) begin
        if (expected_views.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt++;
        end else begin
          want_view = expected_views.pop_front();
          if (status_o !== want_view.status) begin
            $error("status: expected %0d, got %0d", want_view.status, status_o);
            fail_cnt++;
          end
          if (top_value_o !== want_view.top_value) begin
            $error("top_value: expected %0d, got %0d", want_view.top_value, top_value_o);
            fail_cnt++;
          end
          if (top_valid_o !== want_view.top_valid) begin
            $error("top_valid: expected %0b, got %0b", want_view.top_valid, top_valid_o);
            fail_cnt++;
          end
          if (is_empty_o !== want_view.is_empty) begin
            $error("is_empty: expected %0b, got %0b", want_view.is_empty, is_empty_o);
            fail_cnt++;
          end
          if (is_full_o !== want_view.is_full) begin
            $error("is_full: expected %0b, got %0b", want_view.is_full, is_full_o);
            fail_cnt++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(1, 400) <= idle_pct) begin
        recv_gap = $urandom_range(1, 17) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire || out_fire) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    int roll;
    int push_pct;
    logic [DATA_W-1:0] val;
    for (int s = 0; s < NUM_STACKS; s++) fill_cnt[s] = 0;

    add_op(CMD_POP, 32'h0, 0);
    add_op(CMD_POP_AT, 32'h0, 7);
    add_op(CMD_POP_AT, 32'h0, 0);
    add_op(CMD_NOP, 32'hFFFF_FFFF, 7);
    for (int k = 0; k < NUM_STACKS * SUB_DEPTH; k++) add_op(CMD_PUSH, corner_vals[k], 0);
    add_op(CMD_PUSH, 32'hDEAD_0001, 0);
    add_op(CMD_NOP, 32'h0, 0);
    add_op(CMD_POP_AT, 32'h0, 3);
    add_op(CMD_POP_AT, 32'h0, 3);
    add_op(CMD_POP_AT, 32'h0, 3);
    add_op(CMD_POP, 32'h0, 0);
    add_op(CMD_POP_AT, 32'h0, 0);
    add_op(CMD_POP_AT, 32'h0, 0);
    add_op(CMD_POP_AT, 32'h0, 0);

    mode = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      push_pct = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
      roll = $urandom_range(0, 99);
      val = ($urandom_range(0, 3) == 0) ? corner_vals[$urandom_range(0, 15)] : $urandom;
      if (roll < push_pct)
        add_op(CMD_PUSH, val, $urandom_range(0, 7));
      else if (roll < push_pct + (96 - push_pct) / 2)
        add_op(CMD_POP, val, $urandom_range(0, 7));
      else if (roll < 96)
        add_op(CMD_POP_AT, val, $urandom_range(0, 7));
      else
        add_op(CMD_NOP, val, $urandom_range(0, 7));
    end
    total_ops = pending_ops.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < total_ops || expected_views.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
